// ===== hw/rtl/pghash_pkg.sv =====
`timescale 1ns / 1ps
// Constants and shared types of the path string GUID hasher.
// No dependencies; imported by pghash_fold and path_string_guid_hash_top.
package pghash_pkg;

    localparam logic [31:0] FOLD_KEY     = 32'h5C5C5C5C;
    localparam logic [31:0] BYTE_ONES    = 32'h01010101;
    localparam logic [31:0] BYTE_HIGHS   = 32'h80808080;
    localparam logic [31:0] CASE_MASK    = 32'hDFDFDFDF;
    localparam logic [31:0] SLASH_DELTA  = 32'd45;

    // 0xFB8C4D96501 split at bit 32
    localparam logic [31:0] WORD_MULT_LO = 32'hC4D96501;
    localparam logic [11:0] WORD_MULT_HI = 12'hFB8;
    localparam logic [26:0] ACC_MULT     = 27'h633D5F1;
    // 0xAE502812AA7333 split at bit 32
    localparam logic [31:0] LEN_MULT_LO  = 32'h12AA7333;
    localparam logic [23:0] LEN_MULT_HI  = 24'hAE5028;

    localparam int MIX_SHIFT  = 61;
    localparam int WORD_SHIFT = 24;
    localparam int SCALE_W    = 64 - WORD_SHIFT;

    typedef struct packed {
        logic [31:0] fw;    // folded word, masked below the terminator on the last word
        logic        term;  // word holds the terminator
        logic [1:0]  k;     // byte index of the terminator
    } fold_t;

endpackage

// ===== hw/rtl/pghash_fold.sv =====
`timescale 1ns / 1ps
// Word folding and terminator detection for one 32-bit string word.
// Depends on pghash_pkg.
module pghash_fold import pghash_pkg::*; (
    input  logic [31:0] word,
    output fold_t       fold
);

    logic [31:0] x;
    logic [31:0] mark;
    logic [31:0] f;
    logic [31:0] z;
    logic [31:0] lowbit;
    logic [31:0] below;

    always_comb begin
        x      = word ^ FOLD_KEY;
        mark   = ((~x) >> 7) & ((x - BYTE_ONES) >> 7) & BYTE_ONES;
        f      = (word - 32'(mark * SLASH_DELTA)) & CASE_MASK;
        z      = ~word & (word - BYTE_ONES) & BYTE_HIGHS;
        lowbit = z & (~z + 32'd1);
        below  = lowbit - 32'd1;

        fold.term = (z != 32'd0);
        fold.fw   = fold.term ? (f & below) : f;
        case (lowbit)
            32'h0000_0080: fold.k = 2'd0;
            32'h0000_8000: fold.k = 2'd1;
            32'h0080_0000: fold.k = 2'd2;
            default:       fold.k = 2'd3;
        endcase
    end

endmodule

// ===== hw/rtl/path_string_guid_hash_top.sv =====
`timescale 1ns / 1ps
// Top level of the path string GUID hasher: pipeline around the accumulator.
// Depends on pghash_pkg and pghash_fold.
//
//   channel | direction | payload
//   --------+-----------+------------------------------------------------
//   s_      | in        | s_tdata[31:0]  text_word
//   m_      | out       | m_tdata[63:0]  guid, m_tdata[95:64] string_length
//
// One word is taken every cycle while s_tready is high; a result passes the word, multiply,
// sum, accumulator, length and result registers after its terminator. The rate is set by
// the accumulator stage, a constant multiply-add and xor-shift that closes on itself each
// cycle. Reset clears all valid flags, the accumulator and byte count. A stalled result holds
// its stage; words without terminator keep flowing into the accumulator past a full result stage.
module path_string_guid_hash_top import pghash_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // text_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata    // guid [63:0], string_length [95:64]
);

    // stage valids
    logic v0_reg, va_reg, vb_reg, vc_reg, vd_reg, vm_reg;
    logic rdy0, rdya, rdyb, rdyc, rdyd, rdym;

    // payload
    logic [31:0]        word_reg;
    logic [63:0]        plo_reg;
    logic [43:0]        phi_reg;
    logic               terma_reg, termb_reg;
    logic [1:0]         ka_reg, kb_reg;
    logic [SCALE_W-1:0] t_reg;
    logic [63:0]        part_reg, partd_reg;
    logic [31:0]        lenc_reg, lend_reg;
    logic [63:0]        llo_reg;
    logic [31:0]        lhi_reg;
    logic [63:0]        guid_reg;
    logic [31:0]        lenm_reg;

    // accumulator state
    logic [63:0] hash_acc_reg, hash_acc_next;
    logic [31:0] byte_count_reg, byte_count_next;

    fold_t       fold;
    logic [63:0] a_plo;
    logic [43:0] a_phi;
    logic [63:0] b_sum;
    logic [63:0] c_alo;
    logic [58:0] c_ahi;
    logic [63:0] c_s;
    logic [31:0] c_len;
    logic        c_take;
    logic [63:0] d_llo;
    logic [55:0] d_lhi;

    pghash_fold u_fold (
        .word (word_reg),
        .fold (fold)
    );

    // ready chain, from the result register back to the input
    assign rdym     = !vm_reg || m_tready;
    assign rdyd     = !vd_reg || rdym;
    assign rdyc     = !vc_reg || rdyd;
    assign rdyb     = !vb_reg || !termb_reg || rdyc;
    assign rdya     = !va_reg || rdyb;
    assign rdy0     = !v0_reg || rdya;
    assign s_tready = rdy0;

    assign a_plo = 64'(fold.fw) * 64'(WORD_MULT_LO);
    assign a_phi = 44'(fold.fw) * 44'(WORD_MULT_HI);
    assign b_sum = plo_reg + {phi_reg[31:0], 32'd0};

    assign c_alo  = 64'(hash_acc_reg[31:0]) * 64'(ACC_MULT);
    assign c_ahi  = 59'(hash_acc_reg[63:32]) * 59'(ACC_MULT);
    assign c_s    = c_alo + {c_ahi[31:0], 32'd0} + 64'(t_reg);
    assign c_len  = byte_count_reg + 32'(kb_reg);
    assign c_take = vb_reg && rdyb;

    assign d_llo = 64'(lenc_reg) * 64'(LEN_MULT_LO);
    assign d_lhi = 56'(lenc_reg) * 56'(LEN_MULT_HI);

    always_comb begin
        hash_acc_next   = hash_acc_reg;
        byte_count_next = byte_count_reg;
        if (c_take) begin
            if (termb_reg) begin
                hash_acc_next   = 64'd0;
                byte_count_next = 32'd0;
            end else begin
                hash_acc_next   = c_s ^ (c_s >> MIX_SHIFT);
                byte_count_next = byte_count_reg + 32'd4;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg         <= 1'b0;
            va_reg         <= 1'b0;
            vb_reg         <= 1'b0;
            vc_reg         <= 1'b0;
            vd_reg         <= 1'b0;
            vm_reg         <= 1'b0;
            hash_acc_reg   <= 64'd0;
            byte_count_reg <= 32'd0;
        end else begin
            hash_acc_reg   <= hash_acc_next;
            byte_count_reg <= byte_count_next;
            if (rdy0) v0_reg <= s_tvalid;
            if (rdya) va_reg <= v0_reg;
            if (rdyb) vb_reg <= va_reg;
            // only terminator items leave the accumulator stage
            if (rdyc) vc_reg <= c_take && termb_reg;
            if (rdyd) vd_reg <= vc_reg;
            if (rdym) vm_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy0) word_reg <= s_tdata;
        if (rdya) begin
            plo_reg   <= a_plo;
            phi_reg   <= a_phi;
            terma_reg <= fold.term;
            ka_reg    <= fold.k;
        end
        if (rdyb) begin
            t_reg     <= b_sum[63:WORD_SHIFT];
            termb_reg <= terma_reg;
            kb_reg    <= ka_reg;
        end
        if (rdyc) begin
            part_reg <= c_s;
            lenc_reg <= c_len;
        end
        if (rdyd) begin
            partd_reg <= part_reg;
            lend_reg  <= lenc_reg;
            llo_reg   <= d_llo;
            lhi_reg   <= d_lhi[31:0];
        end
        if (rdym) begin
            guid_reg <= partd_reg - llo_reg - {lhi_reg, 32'd0};
            lenm_reg <= lend_reg;
        end
    end

    assign m_tvalid = vm_reg;
    assign m_tdata  = {lenm_reg, guid_reg};

endmodule
